FILE: hw/rtl/ufpd_pkg.sv
// ----------------------------------------------------------------------------
// ufpd_pkg: shared definitions for the form-urlencoded percent decoder
// Character codes, queue sizing and the record that carries the decoded bytes
// of one input transaction from the front end to the back end.
// ----------------------------------------------------------------------------
package ufpd_pkg;

   localparam logic [7:0] CHAR_PLUS      = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT   = 8'h25;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [3:0] HEX_ALPHA_BASE = 4'd10;

   // Most decoded bytes that a single input byte can release.
   localparam int MAX_RESULTS = 3;

   // Default depth of the queue between front end and back end.
   localparam int QUEUE_DEPTH_DEFAULT = 4;

   // Decoded bytes of one input transaction. Entry 0 goes out first; last
   // marks the final entry as the end of the component.
   typedef struct packed {
      logic [MAX_RESULTS-1:0][7:0] bytes;
      logic [1:0]                  count;
      logic                        last;
   } bundle_type;

endpackage

FILE: hw/rtl/ufpd_if.sv
// ----------------------------------------------------------------------------
// ufpd_if: valid/ready channels of the percent decoder
// Request channel carries raw bytes, response channel carries decoded bytes.
// ----------------------------------------------------------------------------
interface ufpd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;

   modport source (output valid, output in_byte, output in_last, input ready);
   modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ufpd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;

   modport source (output valid, output out_byte, output out_last, input ready);
   modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

FILE: hw/rtl/ufpd_front.sv
// ----------------------------------------------------------------------------
// ufpd_front: escape parser of the percent decoder
// Accepts raw bytes, tracks a pending escape and produces the decoded bytes
// of each transaction as one bundle for the queue.
// ----------------------------------------------------------------------------
module ufpd_front
   import ufpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   ufpd_req_if.sink   req,
   input  logic       queue_full,
   output logic       push,
   output bundle_type push_data
);

   typedef enum logic [1:0] {
      HELD_NONE,
      HELD_PERCENT,
      HELD_PAIR
   } held_type;

   // Bit 4 flags a hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] b);
      logic [4:0] r;
      r = 5'd0;
      if (b >= 8'h30 && b <= 8'h39) begin
         r = {1'b1, b[3:0]};
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         r = {1'b1, b[3:0] - 4'd1 + HEX_ALPHA_BASE};
      end
      return r;
   endfunction

   function automatic logic [7:0] plain_byte(input logic [7:0] b);
      return (b == CHAR_PLUS) ? CHAR_SPACE : b;
   endfunction

   held_type   state_ff, state_in;
   logic [7:0] held_ff, held_in;
   logic       accept;
   logic [4:0] hex_h, hex_c;
   logic [MAX_RESULTS-1:0][7:0] res_bytes;
   logic [1:0] res_count;
   logic [7:0] c;
   logic       l;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;
   assign c         = req.in_byte;
   assign l         = req.in_last;
   assign hex_h     = hex_digit(held_ff);
   assign hex_c     = hex_digit(c);

   always_comb begin
      state_in  = HELD_NONE;
      held_in   = held_ff;
      res_bytes = '0;
      res_count = 2'd0;
      case (state_ff)
         HELD_PERCENT: begin
            if (l) begin
               res_bytes[0] = CHAR_PERCENT;
               res_bytes[1] = plain_byte(c);
               res_count    = 2'd2;
            end else begin
               held_in  = c;
               state_in = HELD_PAIR;
            end
         end
         HELD_PAIR: begin
            if (hex_h[4] && hex_c[4]) begin
               res_bytes[0] = {hex_h[3:0], hex_c[3:0]};
               res_count    = 2'd1;
            end else if (held_ff == CHAR_PERCENT) begin
               // The held byte opens a new escape and the new byte joins it.
               res_bytes[0] = CHAR_PERCENT;
               if (l) begin
                  res_bytes[1] = CHAR_PERCENT;
                  res_bytes[2] = plain_byte(c);
                  res_count    = 2'd3;
               end else begin
                  res_count = 2'd1;
                  held_in   = c;
                  state_in  = HELD_PAIR;
               end
            end else begin
               res_bytes[0] = CHAR_PERCENT;
               res_bytes[1] = plain_byte(held_ff);
               if (c == CHAR_PERCENT && !l) begin
                  res_count = 2'd2;
                  state_in  = HELD_PERCENT;
               end else begin
                  res_bytes[2] = plain_byte(c);
                  res_count    = 2'd3;
               end
            end
         end
         default: begin
            if (c == CHAR_PERCENT && !l) begin
               state_in = HELD_PERCENT;
            end else begin
               res_bytes[0] = plain_byte(c);
               res_count    = 2'd1;
            end
         end
      endcase
   end

   assign push            = accept && (res_count != 2'd0);
   assign push_data.bytes = res_bytes;
   assign push_data.count = res_count;
   assign push_data.last  = l;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= HELD_NONE;
      end else if (accept) begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   // The final byte of a component always flushes the pending escape.
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      accept && l |=> state_ff == HELD_NONE)
      else $error("pending escape survived the last byte");

   // The final byte of a component always yields at least one decoded byte.
   a_last_emits: assert property (@(posedge clock) disable iff (reset)
      accept && l |-> push)
      else $error("last byte produced no output");

endmodule

FILE: hw/rtl/ufpd_queue.sv
// ----------------------------------------------------------------------------
// ufpd_queue: bundle queue between front end and back end
// A small first-in first-out buffer of decoded-byte bundles.
// ----------------------------------------------------------------------------
module ufpd_queue
   import ufpd_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  bundle_type push_data,
   output logic       full,
   input  logic       pop,
   output logic       head_valid,
   output bundle_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bundle_type             store_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff,  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(pop && !head_valid))
      else $error("queue read while empty");

endmodule

FILE: hw/rtl/ufpd_back.sv
// ----------------------------------------------------------------------------
// ufpd_back: output serializer of the percent decoder
// Holds one bundle and sends its bytes one per response transaction.
// ----------------------------------------------------------------------------
module ufpd_back
   import ufpd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  bundle_type head,
   output logic       pop,
   ufpd_rsp_if.source rsp
);

   bundle_type cur_ff;
   logic       cur_valid_ff;
   logic [1:0] idx_ff;
   logic [1:0] last_idx;
   logic       at_end;
   logic       fire;
   logic       take;

   assign last_idx = cur_ff.count - 2'd1;
   assign at_end   = (idx_ff == last_idx);
   assign fire     = rsp.valid && rsp.ready;
   assign take     = !cur_valid_ff || (fire && at_end);
   assign pop      = take && head_valid;

   assign rsp.valid    = cur_valid_ff;
   assign rsp.out_byte = cur_ff.bytes[idx_ff];
   assign rsp.out_last = cur_ff.last && at_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (pop) begin
         cur_valid_ff <= 1'b1;
         idx_ff       <= 2'd0;
      end else if (take) begin
         cur_valid_ff <= 1'b0;
         idx_ff       <= 2'd0;
      end else if (fire) begin
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_ff <= head;
      end
   end

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> (cur_ff.count != 2'd0) && (idx_ff <= last_idx))
      else $error("output index outside bundle");

   a_idx_steps: assert property (@(posedge clock) disable iff (reset)
      fire && !at_end |=> cur_valid_ff && (idx_ff == $past(idx_ff) + 2'd1))
      else $error("output index did not advance");

endmodule

FILE: hw/rtl/url_form_percent_decoder.sv
// ----------------------------------------------------------------------------
// url_form_percent_decoder: form-urlencoded component decoder
// Turns '+' into a space and valid %XX escapes into the bytes they encode;
// malformed or truncated escapes pass through literally, '+' as a space.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload               Meaning
//   req_if    in          in_byte, in_last      raw byte, end of component
//   rsp_if    out         out_byte, out_last    decoded byte, end of component
//
// A request transaction is accepted in any cycle in which the bundle queue has
// room, so one raw byte per cycle is taken while output flows freely.
// Each raw byte releases zero to three decoded bytes; the back end sends one
// decoded byte per cycle unless rsp_if stalls, so only bytes with two or
// three results (broken escapes and the end-of-component flush) cost extra
// cycles. Decoded bytes are registered in the queue, then in the back end.
// Synchronous reset clears the pending-escape state and empties the queue.
// When the response side stalls the queue fills, and req_if.ready drops once
// QUEUE_DEPTH bundles are waiting.
// ----------------------------------------------------------------------------
module url_form_percent_decoder
   import ufpd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
   input  logic       clock,
   input  logic       reset,
   ufpd_req_if.sink   req_if,
   ufpd_rsp_if.source rsp_if
);

   // Bundles of decoded bytes from the parser to the serializer.
   bundle_type push_data;
   bundle_type head;
   logic       push;
   logic       pop;
   logic       queue_full;
   logic       head_valid;

   // The front end classifies each raw byte against the pending escape and
   // resolves it into a bundle of up to three decoded bytes.
   ufpd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_if),
      .queue_full (queue_full),
      .push       (push),
      .push_data  (push_data)
   );

   // The queue decouples the parser from stalls on the response channel.
   ufpd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // The back end sends the bytes of each bundle in order, flagging the
   // last byte of a component.
   ufpd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_if)
   );

endmodule

FILE: tb/tb_url_form_percent_decoder.sv
// ----------------------------------------------------------------------------
// tb_url_form_percent_decoder: self-checking bench for the percent decoder
// Drives raw form-urlencoded bytes through the request channel. A directed
// table comes first, then streams of random escapes, plus signs and noise.
// A behavioral decoder in the bench predicts the bytes of untyped rows. The
// response monitor checks each byte against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_url_form_percent_decoder
   import ufpd_pkg::*;
();

   // Minimum number of random raw bytes after the directed table.
   localparam int RANDOM_ITEMS   = 146;
   // Cycles the response side holds ready low during the backlog test.
   localparam int HOLD_CYCLES    = 80;
   // Quiet cycles after the last decoded byte, so any stray byte can show up.
   localparam int SETTLE_CYCLES  = 12;
   // Random index range in which neither side inserts random idle cycles.
   localparam int CALM_FIRST     = 30;
   localparam int CALM_LAST      = 90;
   // Random index at which the response side starts its long hold-off.
   localparam int BACKLOG_AT     = 40;
   // Random index at which the sender stops until all bytes are back.
   localparam int DRAIN_AT       = 120;

   // One row of stimulus. When typed is set, the row carries its own
   // expected decoded bytes; otherwise the bench decoder predicts them.
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
      logic       typed;
      logic [1:0] n_typed;
      logic [7:0] e0;
      logic [7:0] e1;
      logic [7:0] e2;
   } raw_row_type;

   // One decoded byte as it should leave the response channel.
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } decoded_type;

   logic clock;
   logic reset;

   ufpd_req_if req_if ();
   ufpd_rsp_if rsp_if ();

   url_form_percent_decoder DUT (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   // Decoded bytes still to arrive, oldest first.
   decoded_type decoded_q [$];
   int          error_count;

   // Shared pacing flags between the sender and the response process.
   logic       calm;
   logic       backlog_start;

   // Bench copy of the decoder state: how much of an escape is pending and
   // the byte that followed the '%', if any.
   logic [1:0] pend_count;
   logic [7:0] pend_digit;

   // Bytes released by the current raw byte.
   logic [7:0] released [4];
   int         released_n;

   raw_row_type directed_rows [24];

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // ------------------------------------------------------------------------
   // Behavioral decoder
   // ------------------------------------------------------------------------

   // Value of a hex digit of either case, or 16 when the byte is not one.
   function automatic int hex_value(input logic [7:0] b);
      if (b >= 8'h30 && b <= 8'h39) return int'(b) - 'h30;
      if (b >= 8'h61 && b <= 8'h66) return int'(b) - 'h61 + int'(HEX_ALPHA_BASE);
      if (b >= 8'h41 && b <= 8'h46) return int'(b) - 'h41 + int'(HEX_ALPHA_BASE);
      return 16;
   endfunction

   function automatic void release_byte(input logic [7:0] b);
      released[released_n] = b;
      released_n++;
   endfunction

   // Appends one predicted decoded byte behind the older ones.
   function automatic void expect_decoded(input logic [7:0] data, input logic last);
      decoded_type item;
      item.data = data;
      item.last = last;
      decoded_q.insert(decoded_q.size(), item);
   endfunction

   // Handles a byte when no second escape byte is pending. This is also the
   // path on which the bytes of a broken escape are replayed, so a replayed
   // byte may open a new escape or turn into a space.
   function automatic void take_plain(input logic [7:0] c);
      if (pend_count == 2'd1) begin
         pend_digit = c;
         pend_count = 2'd2;
      end else begin
         pend_count = 2'd0;
         if (c == CHAR_PLUS) begin
            release_byte(CHAR_SPACE);
         end else if (c == CHAR_PERCENT) begin
            pend_count = 2'd1;
         end else begin
            release_byte(c);
         end
      end
   endfunction

   // Works out every decoded byte that one raw byte releases, flushing any
   // pending escape when the raw byte ends the component.
   function automatic void decode_raw_byte(input logic [7:0] c, input logic last);
      int         hi;
      int         lo;
      logic [7:0] held;
      released_n = 0;
      if (pend_count == 2'd2) begin
         held       = pend_digit;
         hi         = hex_value(held);
         lo         = hex_value(c);
         pend_count = 2'd0;
         if (hi < 16 && lo < 16) begin
            release_byte(8'(hi * 16 + lo));
         end else begin
            release_byte(CHAR_PERCENT);
            take_plain(held);
            take_plain(c);
         end
      end else begin
         take_plain(c);
      end
      if (last) begin
         if (pend_count == 2'd1 || pend_count == 2'd2) release_byte(CHAR_PERCENT);
         if (pend_count == 2'd2)
            release_byte(pend_digit == CHAR_PLUS ? CHAR_SPACE : pend_digit);
         pend_count = 2'd0;
      end
   endfunction

   // ------------------------------------------------------------------------
   // Random byte sources
   // ------------------------------------------------------------------------

   // A hex digit in upper or lower case.
   function automatic logic [7:0] hex_char();
      int v;
      v = $urandom_range(15);
      if (v < 10) return 8'(8'h30 + v);
      if ($urandom_range(1) == 1) return 8'(8'h41 + v - 10);
      return 8'(8'h61 + v - 10);
   endfunction

   // A byte after '%' that is often not a hex digit: the neighbors of the
   // digit ranges, the two special characters, a digit, or anything at all.
   function automatic logic [7:0] escape_noise();
      case ($urandom_range(5))
         0: return hex_char();
         1: begin
            case ($urandom_range(5))
               0:       return 8'h2F;
               1:       return 8'h3A;
               2:       return 8'h40;
               3:       return 8'h47;
               4:       return 8'h60;
               default: return 8'h67;
            endcase
         end
         2: return CHAR_PERCENT;
         3: return CHAR_PLUS;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // Offers one raw byte, waits for the transaction to be accepted, and then
   // queues the decoded bytes that it must release.
   task automatic offer_raw(input raw_row_type row);
      while (!calm && $urandom_range(99) < 29) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.in_byte <= row.in_byte;
      req_if.in_last <= row.in_last;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);

      // The bench decoder always runs so that its state follows the block.
      // A typed row then replaces the prediction with its own bytes.
      decode_raw_byte(row.in_byte, row.in_last);
      if (row.typed) begin
         released_n  = int'(row.n_typed);
         released[0] = row.e0;
         released[1] = row.e1;
         released[2] = row.e2;
      end
      for (int k = 0; k < released_n; k++)
         expect_decoded(released[k], row.in_last && k == released_n - 1);
   endtask

   initial begin
      raw_row_type row;
      logic [7:0]  chunk [$];
      int          kind;
      int          cut;
      int          random_sent;
      logic        end_here;

      error_count    = 0;
      calm           = 1'b0;
      backlog_start  = 1'b0;
      pend_count     = 2'd0;
      pend_digit     = 8'h00;
      released_n     = 0;
      random_sent    = 0;

      req_if.valid   <= 1'b0;
      req_if.in_byte <= 8'h00;
      req_if.in_last <= 1'b0;
      reset          <= 1'b1;

      // Directed table. Columns: raw byte, last, typed, count, expected bytes.
      directed_rows = '{
         // Plain bytes straight after reset, including both byte extremes.
         '{8'h61,        1'b0, 1'b1, 2'd1, 8'h61,        8'h00,      8'h00},
         '{8'h00,        1'b0, 1'b1, 2'd1, 8'h00,        8'h00,      8'h00},
         '{8'hFF,        1'b0, 1'b1, 2'd1, 8'hFF,        8'h00,      8'h00},
         // A plus sign becomes a space.
         '{CHAR_PLUS,    1'b0, 1'b1, 2'd1, CHAR_SPACE,   8'h00,      8'h00},
         // "%4f": a lower-case escape.
         '{CHAR_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h34,        1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h66,        1'b0, 1'b1, 2'd1, 8'h4F,        8'h00,      8'h00},
         // "%2B": the decoded plus sign is not turned into a space.
         '{CHAR_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h32,        1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h42,        1'b0, 1'b1, 2'd1, CHAR_PLUS,    8'h00,      8'h00},
         // "%G1": a broken escape passes through literally.
         '{CHAR_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h47,        1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h31,        1'b0, 1'b1, 2'd3, CHAR_PERCENT, 8'h47,      8'h31},
         // "%%41": the replayed '%' opens a new escape, ending the component.
         '{CHAR_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         '{CHAR_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h34,        1'b0, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         '{8'h31,        1'b1, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         // A lone '%' as the whole component.
         '{CHAR_PERCENT, 1'b1, 1'b1, 2'd1, CHAR_PERCENT, 8'h00,      8'h00},
         // "%+" cut short: the held plus sign still becomes a space.
         '{CHAR_PERCENT, 1'b0, 1'b1, 2'd0, 8'h00,        8'h00,      8'h00},
         '{CHAR_PLUS,    1'b1, 1'b1, 2'd2, CHAR_PERCENT, CHAR_SPACE, 8'h00},
         // "%+%": broken escape whose replay leaves a '%' for the flush.
         '{CHAR_PERCENT, 1'b0, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         '{CHAR_PLUS,    1'b0, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         '{CHAR_PERCENT, 1'b1, 1'b0, 2'd0, 8'h00,        8'h00,      8'h00},
         // A plain last byte with nothing held.
         '{8'h7A,        1'b1, 1'b1, 2'd1, 8'h7A,        8'h00,      8'h00}
      };

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[k]) offer_raw(directed_rows[k]);

      // Random part. Most chunks are well-formed pieces of a component with
      // random content; some are broken escapes or raw noise. Now and then a
      // chunk ends the component, often cut off in the middle of an escape.
      while (random_sent < RANDOM_ITEMS) begin
         chunk.delete();
         kind = $urandom_range(99);
         if (kind < 30) begin
            chunk.insert(chunk.size(), 8'($urandom_range(255)));
         end else if (kind < 45) begin
            chunk.insert(chunk.size(), CHAR_PLUS);
         end else if (kind < 75) begin
            chunk.insert(chunk.size(), CHAR_PERCENT);
            chunk.insert(chunk.size(), hex_char());
            chunk.insert(chunk.size(), hex_char());
         end else if (kind < 90) begin
            chunk.insert(chunk.size(), CHAR_PERCENT);
            chunk.insert(chunk.size(), escape_noise());
            chunk.insert(chunk.size(), escape_noise());
         end else begin
            chunk.insert(chunk.size(), CHAR_PERCENT);
         end

         end_here = ($urandom_range(7) == 0);
         cut      = end_here ? $urandom_range(chunk.size(), 1) : chunk.size();

         for (int j = 0; j < cut; j++) begin
            calm = (random_sent >= CALM_FIRST && random_sent < CALM_LAST);

            // The response side stalls for a long time here while this side
            // keeps offering bytes, so the bundle queue fills up.
            if (random_sent == BACKLOG_AT) backlog_start = 1'b1;

            // Stop offering until every decoded byte has come back.
            if (random_sent == DRAIN_AT) begin
               req_if.valid <= 1'b0;
               @(posedge clock);
               while (decoded_q.size() != 0) @(posedge clock);
            end

            row = '{chunk[j], end_here && j == cut - 1, 1'b0, 2'd0,
                    8'h00, 8'h00, 8'h00};
            offer_raw(row);
            random_sent++;
         end
      end

      calm         = 1'b0;
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // ------------------------------------------------------------------------
   // Response side
   // ------------------------------------------------------------------------

   // Drives ready once per cycle and checks every accepted transaction
   // against the oldest predicted byte.
   initial begin
      decoded_type want;
      int          hold_left;

      hold_left    = 0;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);

      forever begin
         if (backlog_start) begin
            backlog_start = 1'b0;
            hold_left     = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_if.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_if.ready <= calm || ($urandom_range(99) >= 29);
         end

         @(posedge clock);
         if (rsp_if.valid && rsp_if.ready) begin
            if (decoded_q.size() == 0) begin
               $error("unexpected transaction: out_byte %h, out_last %b",
                      rsp_if.out_byte, rsp_if.out_last);
               error_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_if.out_byte !== want.data) begin
                  $error("out_byte mismatch: expected %h, actual %h",
                         want.data, rsp_if.out_byte);
                  error_count++;
               end
               if (rsp_if.out_last !== want.last) begin
                  $error("out_last mismatch: expected %b, actual %b",
                         want.last, rsp_if.out_last);
                  error_count++;
               end
            end
         end
      end
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #2_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

FILE: sim.f
hw/rtl/ufpd_pkg.sv
hw/rtl/ufpd_if.sv
hw/rtl/ufpd_front.sv
hw/rtl/ufpd_queue.sv
hw/rtl/ufpd_back.sv
hw/rtl/url_form_percent_decoder.sv
tb/tb_url_form_percent_decoder.sv
